// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the core, clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("core check failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("core check failed");

`endif

// ----- rtl/core/mlpfe_pkg.sv -----
`timescale 1ns / 1ps
package mlpfe_pkg;

	// training set and weights
	localparam int NUM_SAMPLES  = 4;
	localparam int WEIGHT_WIDTH = 16;
	localparam int W_W          = 16;
	localparam int CFG_W        = 4;
	localparam int CFG_ADDR_W   = 2;
	localparam int CNT_W        = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;

	// register indexes and reset values
	localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_A = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_B = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_TARGET   = 2'd2;
	localparam logic [CFG_W-1:0] RST_SAMPLE_A = 4'd12;
	localparam logic [CFG_W-1:0] RST_SAMPLE_B = 4'd10;
	localparam logic [CFG_W-1:0] RST_TARGET   = 4'd6;

	// front queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;

	// sigmoid unit
	localparam int SIG_SEGS = 256;
	localparam int SIG_MID  = 128;
	localparam int SIG_LAT  = 5;
	localparam int ARG_W    = 20;
	localparam int SIG_W    = 17;
	localparam logic [63:0] EXP_STEP_Q32 = 64'd3972195407;

	// result widths
	localparam int SUM_W  = 36;
	localparam int FIT_W  = 32;
	localparam int QUO_W  = 63;
	localparam int RAD_W  = 64;
	localparam int ROOT_W = 32;
	localparam int SREM_W = 34;

	typedef logic signed [W_W-1:0] weight_t;

	typedef struct packed {
		weight_t a_h1;
		weight_t a_h2;
		weight_t b_h1;
		weight_t b_h2;
		weight_t h1_out;
		weight_t h2_out;
	} genome_t;

	typedef struct packed {
		logic [CFG_W-1:0] a;
		logic [CFG_W-1:0] b;
		logic [CFG_W-1:0] t;
	} cfg_t;

	// per-sample control riding along the neuron pipeline
	typedef struct packed {
		logic v;
		logic first;
		logic last;
		logic t;
	} ctl_t;

	typedef logic [SIG_W-1:0] sig_tab_t [SIG_SEGS+1];

	// keep the low weight bits, sign extended
	function automatic weight_t fit_weight(weight_t raw);
		return weight_t'($signed(raw[WEIGHT_WIDTH-1:0]));
	endfunction

	// sigmoid points, built at elaboration with a shift-subtract divide
	function automatic sig_tab_t build_sig_tab();
		sig_tab_t tab;
		logic [127:0] e;
		logic [127:0] den;
		logic [127:0] num;
		logic [127:0] rem;
		logic [63:0] quo;
		int m;
		int j;
		e = 128'h1_0000_0000;
		for (m = 0; m <= SIG_MID; m++) begin
			den = 128'h1_0000_0000 + e;
			num = (128'd1 << 48) + (den >> 1);
			rem = '0;
			quo = '0;
			for (j = 63; j >= 0; j--) begin
				rem = {rem[126:0], num[j]};
				if (rem >= den) begin
					rem = rem - den;
					quo[j] = 1'b1;
				end
			end
			tab[SIG_MID+m] = quo[SIG_W-1:0];
			tab[SIG_MID-m] = 17'd65536 - quo[SIG_W-1:0];
			if (m == 0)
				e = {64'd0, EXP_STEP_Q32};
			else
				e = (e * {64'd0, EXP_STEP_Q32} + (128'd1 << 31)) >> 32;
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

// ----- rtl/core/mlpfe_front.sv -----
`timescale 1ns / 1ps
module mlpfe_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  mlpfe_pkg::genome_t                   genome,
	input  logic                                 cfg_we,
	input  logic [mlpfe_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [mlpfe_pkg::CFG_W-1:0]          cfg_wdata,
	output mlpfe_pkg::cfg_t                      cfg,
	output mlpfe_pkg::genome_t                   head,
	output logic                                 head_valid,
	input  logic                                 pop
);
	import mlpfe_pkg::*;

	cfg_t             cfg_q;
	genome_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QPTR_W:0]   cnt_q;
	logic             push;
	genome_t          clean;

	// sample registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a <= RST_SAMPLE_A;
			cfg_q.b <= RST_SAMPLE_B;
			cfg_q.t <= RST_TARGET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SAMPLE_A: cfg_q.a <= cfg_wdata;
				REG_SAMPLE_B: cfg_q.b <= cfg_wdata;
				REG_TARGET:   cfg_q.t <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// weight cleanup at the door
	always_comb begin
		clean.a_h1   = fit_weight(genome.a_h1);
		clean.a_h2   = fit_weight(genome.a_h2);
		clean.b_h1   = fit_weight(genome.b_h1);
		clean.b_h2   = fit_weight(genome.b_h2);
		clean.h1_out = fit_weight(genome.h1_out);
		clean.h2_out = fit_weight(genome.h2_out);
	end

	assign busy       = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign push       = start & ~busy;
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rp_q];

	// genome queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// genome queue storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= clean;
	end

endmodule

// ----- rtl/core/mlpfe_sig.sv -----
`timescale 1ns / 1ps
module mlpfe_sig (
	input  logic                                clk,
	input  logic signed [mlpfe_pkg::ARG_W-1:0]  x,
	output logic [mlpfe_pkg::SIG_W-1:0]         y
);
	import mlpfe_pkg::*;

	localparam int U_W = 13;
	localparam logic signed [ARG_W-1:0] LIM = 20'sd2560;

	logic signed [ARG_W-1:0] x_off;
	logic [U_W-1:0] u_s1;
	logic [U_W-1:0] u_s2;
	logic [1:0]     clip_s1;
	logic [1:0]     clip_s2;
	logic [1:0]     clip_s3;
	logic [1:0]     clip_s4;
	logic [24:0]    i_prod;
	logic [8:0]     i_s2;
	logic [8:0]     i_nx;
	logic [13:0]    i20;
	logic [SIG_W-1:0] lo_t;
	logic [SIG_W-1:0] hi_t;
	logic [4:0]     f_s3;
	logic [SIG_W-1:0] lo_s3;
	logic [SIG_W-1:0] d_s3;
	logic [SIG_W-1:0] lo_s4;
	logic [21:0]    p_s4;
	logic [37:0]    q_prod;
	logic [SIG_W-1:0] y_s5;

	assign x_off = x + LIM;

	// offset and saturation flags
	always_ff @(posedge clk) begin
		clip_s1 <= {x < -LIM, x > LIM};
		u_s1    <= x_off[U_W-1:0];
	end

	// segment index, divide by 20 through a reciprocal
	assign i_prod = 25'(u_s1) * 25'd3277;

	always_ff @(posedge clk) begin
		i_s2    <= i_prod[24:16];
		u_s2    <= u_s1;
		clip_s2 <= clip_s1;
	end

	// table read and fraction
	assign i20  = 14'(i_s2) * 14'd20;
	assign i_nx = i_s2 + 9'd1;

	always_comb begin
		lo_t = SIG_TAB[i_s2];
		if (i_s2 == 9'(SIG_SEGS))
			hi_t = lo_t;
		else
			hi_t = SIG_TAB[i_nx];
		if (hi_t < lo_t)
			hi_t = lo_t;
	end

	always_ff @(posedge clk) begin
		f_s3    <= 5'(u_s2 - i20[U_W-1:0]);
		lo_s3   <= lo_t;
		d_s3    <= hi_t - lo_t;
		clip_s3 <= clip_s2;
	end

	// interpolation product
	always_ff @(posedge clk) begin
		p_s4    <= 22'(d_s3) * 22'(f_s3) + 22'd10;
		lo_s4   <= lo_s3;
		clip_s4 <= clip_s3;
	end

	// divide by 20 and add the base point
	assign q_prod = 38'(p_s4) * 38'd52429;

	always_ff @(posedge clk) begin
		if (clip_s4[1])
			y_s5 <= '0;
		else if (clip_s4[0])
			y_s5 <= 17'd65536;
		else
			y_s5 <= lo_s4 + q_prod[36:20];
	end

	assign y = y_s5;

endmodule

// ----- rtl/core/mlpfe_back.sv -----
`timescale 1ns / 1ps
module mlpfe_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mlpfe_pkg::cfg_t                cfg,
	input  mlpfe_pkg::genome_t             head,
	input  logic                           head_valid,
	output logic                           pop,
	output logic                           sum_valid,
	output logic [mlpfe_pkg::SUM_W-1:0]    sum
);
	import mlpfe_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             last_smp;
	logic             in_rng;
	logic             a_bit;
	logic             b_bit;
	logic             t_bit;
	logic signed [ARG_W-1:0] arg1;
	logic signed [ARG_W-1:0] arg2;
	ctl_t             ctl_s1;
	logic signed [ARG_W-1:0] arg1_s1;
	logic signed [ARG_W-1:0] arg2_s1;
	weight_t          w4_s1;
	weight_t          w5_s1;
	ctl_t             hdly_q [SIG_LAT];
	weight_t          w4_dly_q [SIG_LAT];
	weight_t          w5_dly_q [SIG_LAT];
	logic [SIG_W-1:0] h1;
	logic [SIG_W-1:0] h2;
	ctl_t             ctl_s7;
	logic signed [33:0] p1_s7;
	logic signed [33:0] p2_s7;
	logic signed [34:0] psum;
	ctl_t             ctl_s8;
	logic signed [ARG_W-1:0] arg3_s8;
	ctl_t             odly_q [SIG_LAT];
	logic [SIG_W-1:0] o;
	ctl_t             ctl_s14;
	logic signed [17:0] e;
	logic signed [35:0] sq_full;
	logic [33:0]      sq_s14;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W:0]   acc_nx;
	logic [SUM_W-1:0] acc_sat;
	logic             sum_valid_q;
	logic [SUM_W-1:0] sum_q;

	// sample issue, one per cycle from the queue head while the head is valid
	assign last_smp = (cnt_q == CNT_W'(NUM_SAMPLES-1));
	assign in_rng   = (int'(cnt_q) < CFG_W);
	assign a_bit    = in_rng & cfg.a[2'(cnt_q)];
	assign b_bit    = in_rng & cfg.b[2'(cnt_q)];
	assign t_bit    = in_rng & cfg.t[2'(cnt_q)];
	assign pop      = head_valid & last_smp;

	assign arg1 = (a_bit ? ARG_W'(head.a_h1) : '0) + (b_bit ? ARG_W'(head.b_h1) : '0);
	assign arg2 = (a_bit ? ARG_W'(head.a_h2) : '0) + (b_bit ? ARG_W'(head.b_h2) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (head_valid)
			cnt_q <= last_smp ? '0 : cnt_q + 1'b1;
	end

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s7  <= '0;
			ctl_s8  <= '0;
			ctl_s14 <= '0;
			for (int k = 0; k < SIG_LAT; k++) begin
				hdly_q[k] <= '0;
				odly_q[k] <= '0;
			end
		end else begin
			ctl_s1 <= '{v: head_valid, first: (cnt_q == '0), last: last_smp, t: t_bit};
			hdly_q[0] <= ctl_s1;
			odly_q[0] <= ctl_s8;
			for (int k = 1; k < SIG_LAT; k++) begin
				hdly_q[k] <= hdly_q[k-1];
				odly_q[k] <= odly_q[k-1];
			end
			ctl_s7  <= hdly_q[SIG_LAT-1];
			ctl_s8  <= ctl_s7;
			ctl_s14 <= odly_q[SIG_LAT-1];
		end
	end

	// hidden layer arguments and output weights
	always_ff @(posedge clk) begin
		arg1_s1 <= arg1;
		arg2_s1 <= arg2;
		w4_s1   <= head.h1_out;
		w5_s1   <= head.h2_out;
		w4_dly_q[0] <= w4_s1;
		w5_dly_q[0] <= w5_s1;
		for (int k = 1; k < SIG_LAT; k++) begin
			w4_dly_q[k] <= w4_dly_q[k-1];
			w5_dly_q[k] <= w5_dly_q[k-1];
		end
	end

	mlpfe_sig u_sig_h1 (.clk(clk), .x(arg1_s1), .y(h1));
	mlpfe_sig u_sig_h2 (.clk(clk), .x(arg2_s1), .y(h2));

	// output neuron products
	always_ff @(posedge clk) begin
		p1_s7 <= $signed({1'b0, h1}) * w4_dly_q[SIG_LAT-1];
		p2_s7 <= $signed({1'b0, h2}) * w5_dly_q[SIG_LAT-1];
	end

	// sum and round half up to Q8.8
	assign psum = 35'(p1_s7) + 35'(p2_s7) + 35'sd32768;

	always_ff @(posedge clk) begin
		arg3_s8 <= ARG_W'(psum >>> 16);
	end

	mlpfe_sig u_sig_out (.clk(clk), .x(arg3_s8), .y(o));

	// squared error
	assign e       = (odly_q[SIG_LAT-1].t ? 18'sd65536 : 18'sd0) - $signed({1'b0, o});
	assign sq_full = e * e;

	always_ff @(posedge clk) begin
		sq_s14 <= sq_full[33:0];
	end

	// saturating accumulate over the samples of one genome
	assign acc_nx  = (ctl_s14.first ? '0 : {1'b0, acc_q}) + (SUM_W+1)'(sq_s14);
	assign acc_sat = acc_nx[SUM_W] ? '1 : acc_nx[SUM_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl_s14.v) begin
			acc_q <= acc_sat;
			sum_q <= (acc_sat == '0) ? SUM_W'(1) : acc_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sum_valid_q <= 1'b0;
		else
			sum_valid_q <= ctl_s14.v & ctl_s14.last;
	end

	assign sum_valid = sum_valid_q;
	assign sum       = sum_q;

endmodule

// ----- rtl/core/mlpfe_rsqrt.sv -----
`timescale 1ns / 1ps
module mlpfe_rsqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [mlpfe_pkg::SUM_W-1:0]    s,
	output logic                           out_valid,
	output logic [mlpfe_pkg::FIT_W-1:0]    root,
	output logic [mlpfe_pkg::SUM_W-1:0]    s_out
);
	import mlpfe_pkg::*;

	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [SUM_W-1:0] den;
		logic [QUO_W-1:0] quo;
	} div_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] rt;
		logic [SUM_W-1:0]  den;
	} sqr_t;

	div_t dv_q  [QUO_W+1];
	logic dvv_q [QUO_W+1];
	sqr_t sr_q  [ROOT_W+1];
	logic srv_q [ROOT_W+1];

	// valid bits through both pipelines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QUO_W; k++)
				dvv_q[k] <= 1'b0;
			for (int k = 0; k <= ROOT_W; k++)
				srv_q[k] <= 1'b0;
		end else begin
			dvv_q[0] <= in_valid;
			for (int k = 1; k <= QUO_W; k++)
				dvv_q[k] <= dvv_q[k-1];
			srv_q[0] <= dvv_q[QUO_W];
			for (int k = 1; k <= ROOT_W; k++)
				srv_q[k] <= srv_q[k-1];
		end
	end

	// divider entry: 2^62 over the error sum
	always_ff @(posedge clk) begin
		dv_q[0] <= '{rem: '0, den: s, quo: '0};
	end

	// restoring divide, one quotient bit per stage
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		logic [SUM_W:0] cur;
		logic           ge;
		assign cur = {dv_q[k].rem, (k == 0) ? 1'b1 : 1'b0};
		assign ge  = (cur >= {1'b0, dv_q[k].den});
		always_ff @(posedge clk) begin
			dv_q[k+1].den <= dv_q[k].den;
			dv_q[k+1].quo <= {dv_q[k].quo[QUO_W-2:0], ge};
			dv_q[k+1].rem <= ge ? SUM_W'(cur - {1'b0, dv_q[k].den}) : SUM_W'(cur);
		end
	end

	// square root entry
	always_ff @(posedge clk) begin
		sr_q[0] <= '{rad: RAD_W'(dv_q[QUO_W].quo), rem: '0, rt: '0, den: dv_q[QUO_W].den};
	end

	// digit-by-digit square root, one root bit per stage
	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic [SREM_W+1:0] cur;
		logic [SREM_W+1:0] trial;
		logic              ge;
		assign cur   = {sr_q[k].rem, sr_q[k].rad[RAD_W-1:RAD_W-2]};
		assign trial = (SREM_W+2)'({sr_q[k].rt, 2'b01});
		assign ge    = (cur >= trial);
		always_ff @(posedge clk) begin
			sr_q[k+1].rad <= {sr_q[k].rad[RAD_W-3:0], 2'b00};
			sr_q[k+1].den <= sr_q[k].den;
			sr_q[k+1].rt  <= {sr_q[k].rt[ROOT_W-2:0], ge};
			sr_q[k+1].rem <= ge ? SREM_W'(cur - trial) : SREM_W'(cur);
		end
	end

	assign out_valid = srv_q[ROOT_W];
	assign root      = sr_q[ROOT_W].rt;
	assign s_out     = sr_q[ROOT_W].den;

endmodule

// ----- rtl/core/mlp_2_2_1_fitness_evaluator_core.sv -----
`timescale 1ns / 1ps
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+-----------------------------
// genome   | w_a_to_h1 .. w_h2_to_out (Q8.8)         | start high, busy low
// config   | cfg_we, cfg_addr, cfg_wdata             | cfg_we high, no wait
// result   | fitness_value, error_sum                | done high for one cycle
//
// A genome's NUM_SAMPLES samples enter the shared neuron pipeline one sample per cycle while
// the queue head is valid, and a new genome can follow before the last one is through; a
// two-word queue sits in front. Each result then passes through the one-bit-per-stage
// divide and square root pipelines.
// busy is high only while the queue is full. The result side never stalls.
// Reset clears the sample registers to their defaults and empties every pipeline.
`include "assert_macros.svh"
module mlp_2_2_1_fitness_evaluator_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  mlpfe_pkg::weight_t                    w_a_to_h1,
	input  mlpfe_pkg::weight_t                    w_a_to_h2,
	input  mlpfe_pkg::weight_t                    w_b_to_h1,
	input  mlpfe_pkg::weight_t                    w_b_to_h2,
	input  mlpfe_pkg::weight_t                    w_h1_to_out,
	input  mlpfe_pkg::weight_t                    w_h2_to_out,
	input  logic                                  cfg_we,
	input  logic [mlpfe_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [mlpfe_pkg::CFG_W-1:0]           cfg_wdata,
	output logic                                  done,
	output logic [mlpfe_pkg::FIT_W-1:0]           fitness_value,
	output logic [mlpfe_pkg::SUM_W-1:0]           error_sum
);
	import mlpfe_pkg::*;

	genome_t          genome;
	genome_t          head;
	cfg_t             cfg;
	logic             head_valid;
	logic             pop;
	logic             sum_valid;
	logic [SUM_W-1:0] sum;

	assign genome = '{a_h1: w_a_to_h1, a_h2: w_a_to_h2, b_h1: w_b_to_h1,
		b_h2: w_b_to_h2, h1_out: w_h1_to_out, h2_out: w_h2_to_out};

	mlpfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.genome     (genome),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.cfg        (cfg),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	mlpfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.sum_valid  (sum_valid),
		.sum        (sum)
	);

	mlpfe_rsqrt u_rsqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sum_valid),
		.s         (sum),
		.out_valid (done),
		.root      (fitness_value),
		.s_out     (error_sum)
	);

	// checks
	`CHK_NOW(a_sum_floor, done, error_sum != '0)
	`CHK_NOW(a_fit_range, done, fitness_value <= 32'h8000_0000)
	`CHK_NEXT(a_done_gap, done, !done)

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import mlpfe_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 150;

	typedef struct {
		logic [FIT_W-1:0] fit;
		logic [SUM_W-1:0] sum;
	} score_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	weight_t w_a_to_h1, w_a_to_h2, w_b_to_h1, w_b_to_h2, w_h1_to_out, w_h2_to_out;
	logic cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_W-1:0] cfg_wdata;
	logic done;
	logic [FIT_W-1:0] fitness_value;
	logic [SUM_W-1:0] error_sum;

	// training set mirror and expected scores
	logic [CFG_W-1:0] train_a, train_b, train_t;
	logic [16:0] curve_pts [0:SIG_SEGS];
	score_t pending_scores [$];
	int mismatches;
	int genomes_sent;
	int scores_seen;
	int cfg_writes;
	int idle_cycles;

	mlp_2_2_1_fitness_evaluator_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.w_a_to_h1(w_a_to_h1), .w_a_to_h2(w_a_to_h2),
		.w_b_to_h1(w_b_to_h1), .w_b_to_h2(w_b_to_h2),
		.w_h1_to_out(w_h1_to_out), .w_h2_to_out(w_h2_to_out),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.done(done), .fitness_value(fitness_value), .error_sum(error_sum)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// logistic curve points, mirrored around the middle
	task automatic make_curve();
		logic [127:0] e;
		logic [63:0] den;
		logic [63:0] q;
		e = 128'h1_0000_0000;
		for (int m = 0; m <= SIG_MID; m++) begin
			den = 64'h1_0000_0000 + e[63:0];
			q = ((64'd1 << 48) + den / 2) / den;
			curve_pts[SIG_MID + m] = q[16:0];
			curve_pts[SIG_MID - m] = 17'd65536 - q[16:0];
			if (m == 0)
				e = 128'd3972195407;
			else
				e = (e * 128'd3972195407 + (128'd1 << 31)) >> 32;
		end
	endtask

	// interpolated logistic on a Q8.8 argument
	function automatic logic [16:0] squash(input logic signed [63:0] x);
		logic [63:0] u, seg, frac, lo, hi;
		if (x < -64'sd2560)
			return 17'd0;
		if (x > 64'sd2560)
			return 17'd65536;
		u = x + 64'sd2560;
		seg = u / 20;
		frac = u % 20;
		if (seg >= SIG_SEGS)
			return curve_pts[SIG_SEGS];
		lo = curve_pts[seg];
		hi = curve_pts[seg + 1];
		if (hi < lo)
			hi = lo;
		return 17'(lo + ((hi - lo) * frac + 10) / 20);
	endfunction

	// error sum over the training set and its inverse root
	function automatic score_t score_genome(input weight_t w [6]);
		score_t r;
		logic signed [63:0] wa1, wa2, wb1, wb2, wo1, wo2;
		logic signed [63:0] h1, h2, p, q, o, e;
		logic [63:0] total, n, root, bit_v;
		logic a, b, t;
		wa1 = w[0]; wa2 = w[1]; wb1 = w[2]; wb2 = w[3]; wo1 = w[4]; wo2 = w[5];
		total = 0;
		for (int s = 0; s < NUM_SAMPLES; s++) begin
			a = train_a[s];
			b = train_b[s];
			t = train_t[s];
			h1 = {47'd0, squash((a ? wa1 : 64'sd0) + (b ? wb1 : 64'sd0))};
			h2 = {47'd0, squash((a ? wa2 : 64'sd0) + (b ? wb2 : 64'sd0))};
			p = h1 * wo1 + h2 * wo2;
			q = (p + 64'sd32768) >>> 16;
			o = {47'd0, squash(q)};
			e = (t ? 64'sd65536 : 64'sd0) - o;
			total = total + 64'(e * e);
			if (total > 64'h0F_FFFF_FFFF)
				total = 64'h0F_FFFF_FFFF;
		end
		if (total == 0)
			total = 1;
		n = (64'd1 << 62) / total;
		root = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n)
			bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (n >= root + bit_v) begin
				n = n - (root + bit_v);
				root = (root >> 1) + bit_v;
			end else begin
				root = root >> 1;
			end
			bit_v = bit_v >> 2;
		end
		r.fit = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
		r.sum = total[35:0];
		return r;
	endfunction

	// send one genome word; returns at a falling edge with start still high
	task automatic send_genome(input weight_t w [6]);
		w_a_to_h1 = w[0];
		w_a_to_h2 = w[1];
		w_b_to_h1 = w[2];
		w_b_to_h2 = w[3];
		w_h1_to_out = w[4];
		w_h2_to_out = w[5];
		start = 1'b1;
		while (busy)
			@(negedge clk);
		pending_scores.push_back(score_genome(w));
		genomes_sent++;
		@(negedge clk);
	endtask

	task automatic pause(input int cycles);
		start = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// register write once the pipeline is empty
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
		start = 1'b0;
		while (pending_scores.size() != 0)
			@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		case (idx)
			REG_SAMPLE_A: begin
				train_a = val;
			end
			REG_SAMPLE_B: begin
				train_b = val;
			end
			REG_TARGET: begin
				train_t = val;
			end
			default: begin
			end
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_training(input logic [CFG_W-1:0] a, b, t);
		write_reg(REG_SAMPLE_A, a);
		write_reg(REG_SAMPLE_B, b);
		write_reg(REG_TARGET, t);
	endtask

	function automatic void fill(output weight_t w [6], input weight_t v);
		foreach (w[k])
			w[k] = v;
	endfunction

	// corner weights under the reset training set
	task automatic test_directed_weights();
		weight_t w [6];
		weight_t edges [10] = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sd2560, 16'sd2561,
			-16'sd2560, -16'sd2561, 16'sd2559, 16'sh5555, -16'sh5556};
		foreach (edges[i]) begin
			fill(w, edges[i]);
			send_genome(w);
		end
		// hidden sums straddling the curve limits one input at a time
		w = '{16'sd2561, -16'sd2561, 16'sd0, 16'sd1, 16'sd20, -16'sd20};
		send_genome(w);
		w = '{16'sd1280, 16'sd1280, 16'sd1281, -16'sd1281, 16'sd7, -16'sd13};
		send_genome(w);
		pause(3);
	endtask

	// training sets that zero or saturate the error, and an ignored register index
	task automatic test_training_sets();
		weight_t w [6];
		set_training(4'hF, 4'hF, 4'hF);
		fill(w, 16'sh7FFF);
		send_genome(w);
		fill(w, -16'sh8000);
		send_genome(w);
		set_training(4'h0, 4'h0, 4'h0);
		w = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sh8000, -16'sh8000};
		send_genome(w);
		w = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF};
		send_genome(w);
		write_reg(2'd3, 4'hF);
		send_genome(w);
		set_training(4'h5, 4'h3, 4'h9);
		w = '{16'sd300, -16'sd300, 16'sd600, -16'sd10, 16'sd2000, -16'sd1999};
		send_genome(w);
		pause(2);
	endtask

	function automatic weight_t rand_weight();
		case ($urandom_range(0, 9))
			0, 1: return weight_t'($urandom);
			2: return weight_t'($urandom_range(0, 40)) - 16'sd20 + ($urandom_range(0, 1) ?
				16'sd2560 : -16'sd2560);
			default: return weight_t'($urandom_range(0, 6000)) - 16'sd3000;
		endcase
	endfunction

	// random genomes in bursts, with a one-in-four chance of a fresh training set before each burst
	task automatic test_random_genomes(input int count);
		weight_t w [6];
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 3) == 0)
				set_training(4'($urandom), 4'($urandom), 4'($urandom));
			burst = $urandom_range(1, 60);
			for (int i = 0; i < burst && left > 0; i++) begin
				foreach (w[k])
					w[k] = rand_weight();
				send_genome(w);
				left--;
				if ($urandom_range(0, 4) == 0 && burst < 40)
					pause($urandom_range(1, 6));
			end
			pause($urandom_range(0, 1) ? 0 : $urandom_range(1, 30));
		end
		start = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		score_t want;
		if (done) begin
			scores_seen++;
			if (pending_scores.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: fitness %0d sum %0d", fitness_value, error_sum);
			end else begin
				want = pending_scores.pop_front();
				if (fitness_value !== want.fit || error_sum !== want.sum) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d: fitness exp %0d got %0d, sum exp %0d got %0d",
							scores_seen - 1, want.fit, fitness_value, want.sum, error_sum);
				end
			end
		end
	end

	// watchdog on cycles with no accepted word in either direction
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout with %0d scores outstanding", pending_scores.size());
			$display("[mlp_2_2_1_fitness_evaluator_core] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		w_a_to_h1 = '0;
		w_a_to_h2 = '0;
		w_b_to_h1 = '0;
		w_b_to_h2 = '0;
		w_h1_to_out = '0;
		w_h2_to_out = '0;
		train_a = RST_SAMPLE_A;
		train_b = RST_SAMPLE_B;
		train_t = RST_TARGET;
		mismatches = 0;
		genomes_sent = 0;
		scores_seen = 0;
		cfg_writes = 0;
		idle_cycles = 0;
		make_curve();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_weights();
		test_training_sets();
		test_random_genomes(1350);

		while (pending_scores.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("%0d genomes scored over %0d register writes, %0d mismatches",
			genomes_sent, cfg_writes, mismatches);
		if (mismatches == 0)
			$display("[mlp_2_2_1_fitness_evaluator_core] OK");
		else
			$display("[mlp_2_2_1_fitness_evaluator_core] ERROR");
		$finish;
	end

endmodule
